// ----- design/rta_pkg.sv -----
// Shared constants, register indexes and the symbol lookup for the radix-to-ASCII converter.
// No dependencies; every other design file but rta_ram imports this package.
`default_nettype none

package rta_pkg;

  localparam int DEF_VALUE_WIDTH = 64;
  localparam int DEF_MAX_RADIX   = 16;

  localparam int RADIX_W    = 5;
  localparam int SYM_W      = 8;
  localparam int ALPHA_W    = 64;
  localparam int SYM_IDX_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RADIX_W-1:0] RESET_RADIX        = 5'd10;
  localparam logic [ALPHA_W-1:0] RESET_SYMBOLS_LOW  = 64'h3736353433323130;
  localparam logic [ALPHA_W-1:0] RESET_SYMBOLS_HIGH = 64'h0000000000003938;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  function automatic logic [SYM_W-1:0] digit_symbol(
    input logic [ALPHA_W-1:0]   sym_low,
    input logic [ALPHA_W-1:0]   sym_high,
    input logic [SYM_IDX_W-1:0] digit
  );
    logic [SYM_W-1:0] sym;
    if (digit[SYM_IDX_W-1]) begin
      sym = sym_high[digit[SYM_IDX_W-2:0]*SYM_W +: SYM_W];
    end else begin
      sym = sym_low[digit[SYM_IDX_W-2:0]*SYM_W +: SYM_W];
    end
    return sym;
  endfunction

endpackage

`default_nettype wire

// ----- design/radix_to_ascii_converter.sv -----
// Top level of the radix-to-ASCII converter: configuration registers, front end, queue,
// back end and symbol lookup. Depends on rta_pkg, rta_front, rta_queue and rta_back.
//
// Usage:
//   Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is always high.
//   Index 0 is the radix (clamped into 2..MAX_RADIX), 1 and 2 the symbol bytes for
//   digits 0..7 and 8..15. Index 3 is ignored. Write only while no request is in flight.
//   Requests: a value is taken when start is high and busy is low. Up to two requests
//   wait in a queue while the back end converts an earlier one.
//   Results: one symbol per cycle on out_symbol with out_valid, most significant digit
//   first, out_last_symbol on the final digit. Zero gives the single digit-0 symbol.
//   The receiver cannot stall; every symbol is shown for exactly one cycle.
//   Operation: the back end picks up a request from the queue, then for each digit divides
//   the running quotient one byte-wide step per significant byte, then reads the symbols
//   back from the digit RAM, whose read data is registered.
//   Reset: synchronous, active low; clears the queue and the back end, restores radix 10
//   and the alphabet "0123456789" followed by zero bytes.
`default_nettype none

module radix_to_ascii_converter
  import rta_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int MAX_RADIX   = DEF_MAX_RADIX
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output      logic                   busy,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  output      logic                   out_valid,
  output      logic [SYM_W-1:0]       out_symbol,
  output      logic                   out_last_symbol,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ALPHA_W-1:0]     cfg_data
);

  localparam int NBYTES = (VALUE_WIDTH + 7) / 8;
  localparam int PAD_W  = NBYTES * 8;
  localparam int BIDX_W = (NBYTES > 1) ? $clog2(NBYTES) : 1;
  localparam int DIG_W  = $clog2(MAX_RADIX);

  logic [RADIX_W-1:0] radix_r;
  logic [ALPHA_W-1:0] sym_low_r;
  logic [ALPHA_W-1:0] sym_high_r;
  logic [RADIX_W-1:0] eff_radix;

  logic               push;
  logic [PAD_W-1:0]   push_value;
  logic [BIDX_W-1:0]  push_top;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [PAD_W+BIDX_W-1:0] q_data;

  logic               dig_valid;
  logic [DIG_W-1:0]   dig_value;
  logic               dig_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= RESET_RADIX;
      sym_low_r  <= RESET_SYMBOLS_LOW;
      sym_high_r <= RESET_SYMBOLS_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIX:        radix_r    <= cfg_data[RADIX_W-1:0];
        CFG_SYMBOLS_LOW:  sym_low_r  <= cfg_data;
        CFG_SYMBOLS_HIGH: sym_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate the radix into 2..MAX_RADIX
  always_comb begin
    if (radix_r < RADIX_W'(2)) begin
      eff_radix = RADIX_W'(2);
    end else if (radix_r > RADIX_W'(MAX_RADIX)) begin
      eff_radix = RADIX_W'(MAX_RADIX);
    end else begin
      eff_radix = radix_r;
    end
  end

  rta_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .start     (start),
    .queue_full(q_full),
    .in_value  (in_value),
    .push      (push),
    .push_value(push_value),
    .push_top  (push_top)
  );

  assign busy = q_full;

  rta_queue #(
    .WIDTH(PAD_W + BIDX_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_top, push_value}),
    .pop      (q_pop),
    .pop_data (q_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  rta_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_RADIX  (MAX_RADIX)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .radix    (eff_radix),
    .q_empty  (q_empty),
    .q_value  (q_data[PAD_W-1:0]),
    .q_top    (q_data[PAD_W+BIDX_W-1:PAD_W]),
    .q_pop    (q_pop),
    .dig_valid(dig_valid),
    .dig_value(dig_value),
    .dig_last (dig_last)
  );

  assign out_valid       = dig_valid;
  assign out_last_symbol = dig_last;
  assign out_symbol      = digit_symbol(sym_low_r, sym_high_r, SYM_IDX_W'(dig_value));

endmodule

`default_nettype wire

// ----- design/rta_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the digit stack of the converter.
`default_nettype none

module rta_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- design/rta_front.sv -----
// Front end: takes requests, pads the value to whole bytes and finds its top nonzero byte.
// Depends on rta_pkg; feeds rta_queue.
`default_nettype none

module rta_front
  import rta_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int NBYTES     = (VALUE_WIDTH + 7) / 8,
  localparam int PAD_W      = NBYTES * 8,
  localparam int BIDX_W     = (NBYTES > 1) ? $clog2(NBYTES) : 1
) (
  input  wire logic                   start,
  input  wire logic                   queue_full,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  output      logic                   push,
  output      logic [PAD_W-1:0]       push_value,
  output      logic [BIDX_W-1:0]      push_top
);

  assign push       = start && !queue_full;
  assign push_value = PAD_W'(in_value);

  // Highest nonzero byte; a zero value still gets one byte of work
  always_comb begin
    push_top = '0;
    for (int i = 0; i < NBYTES; i++) begin
      if (push_value[i*8 +: 8] != 8'd0) begin
        push_top = BIDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/rta_queue.sv -----
// Short request queue between front end and back end, built from flops.
// Depends on rta_pkg for its depth.
`default_nettype none

module rta_queue
  import rta_pkg::*;
#(
  parameter int WIDTH = 67,
  localparam int PTR_W = $clog2(QUEUE_DEPTH),
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data,
  output      logic             full,
  output      logic             empty
);

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/rta_back.sv -----
// Back end: repeated division by the radix, a byte per cycle, digits stacked in a RAM,
// then read back most significant first. Depends on rta_pkg and rta_ram.
`default_nettype none

module rta_back
  import rta_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int MAX_RADIX   = DEF_MAX_RADIX,
  localparam int NBYTES     = (VALUE_WIDTH + 7) / 8,
  localparam int PAD_W      = NBYTES * 8,
  localparam int BIDX_W     = (NBYTES > 1) ? $clog2(NBYTES) : 1,
  localparam int DIG_W      = $clog2(MAX_RADIX),
  localparam int AW         = $clog2(VALUE_WIDTH),
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [RADIX_W-1:0] radix,
  input  wire logic               q_empty,
  input  wire logic [PAD_W-1:0]   q_value,
  input  wire logic [BIDX_W-1:0]  q_top,
  output      logic               q_pop,
  output      logic               dig_valid,
  output      logic [DIG_W-1:0]   dig_value,
  output      logic               dig_last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [PAD_W-1:0]  val_r, val_nxt;
  logic [BIDX_W-1:0] idx_r, idx_nxt;
  logic [BIDX_W-1:0] top_r, top_nxt;
  logic [DIG_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic              plast_r, plast_nxt;

  logic [7:0]        cur_byte;
  logic [7:0]        qbyte;
  logic [DIG_W-1:0]  rem_step;
  logic              wr_en;

  assign cur_byte = val_r[idx_r*8 +: 8];

  // Eight restoring steps of long division by the radix
  always_comb begin
    logic [DIG_W:0]   t;
    logic [DIG_W-1:0] r;
    r     = rem_r;
    qbyte = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r, cur_byte[i]};
      if (RADIX_W'(t) >= radix) begin
        qbyte[i] = 1'b1;
        t        = t - (DIG_W+1)'(radix);
      end
      r = t[DIG_W-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    top_nxt   = top_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    pend_nxt  = 1'b0;
    plast_nxt = 1'b0;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          val_nxt   = q_value;
          top_nxt   = q_top;
          idx_nxt   = q_top;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        val_nxt[idx_r*8 +: 8] = qbyte;
        if (idx_r != '0) begin
          idx_nxt = idx_r - 1'b1;
          rem_nxt = rem_step;
        end else begin
          // remainder is the next digit; quotient stays in place
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          rem_nxt = '0;
          if (val_nxt == '0) begin
            ptr_nxt   = cnt_r[AW-1:0];
            state_nxt = ST_EMIT;
          end else begin
            // quotient loses at most four bits, so at most one byte drops
            if (val_nxt[top_r*8 +: 8] == 8'd0 && top_r != '0) begin
              top_nxt = top_r - 1'b1;
            end
            idx_nxt = top_nxt;
          end
        end
      end
      ST_EMIT: begin
        pend_nxt  = 1'b1;
        plast_nxt = (ptr_r == '0);
        if (ptr_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r - 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    top_r   <= top_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    ptr_r   <= ptr_nxt;
    plast_r <= plast_nxt;
  end

  rta_ram #(
    .WIDTH(DIG_W),
    .DEPTH(VALUE_WIDTH)
  ) u_digit_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(cnt_r[AW-1:0]),
    .wr_data(rem_step),
    .rd_addr(ptr_r),
    .rd_data(dig_value)
  );

  assign dig_valid = pend_r;
  assign dig_last  = plast_r;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for radix_to_ascii_converter: directed table, then random phases per setting.
// Predicts the digit symbols from its own copy of the registers where a row gives no text. Depends on rta_pkg.
`timescale 1ns / 1ps

module tb
  import rta_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE        = 2'd3;
  localparam logic [ALPHA_W-1:0]   HEX_SYMBOLS_HIGH = 64'h4645444342413938;
  localparam logic [63:0]          ALL_ONES         = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } glyph_t;

  typedef enum logic {ROW_CONVERT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [63:0]           data;
    logic [511:0]          text;  // zero: take the symbols from the predictor
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [63:0]          in_value = '0;
  logic                 out_valid;
  logic [SYM_W-1:0]     out_symbol;
  logic                 out_last_symbol;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RADIX;
  logic [ALPHA_W-1:0]   cfg_data = '0;

  // shadow copy of the configuration
  logic [RADIX_W-1:0]   base_reg = RESET_RADIX;
  logic [ALPHA_W-1:0]   glyphs_low = RESET_SYMBOLS_LOW;
  logic [ALPHA_W-1:0]   glyphs_high = RESET_SYMBOLS_HIGH;

  glyph_t pending_symbols[$];
  glyph_t want;
  row_t   plan [28];
  bit     steady = 1'b0;
  int     fail_count = 0;
  int     values_sent = 0;
  int     symbols_seen = 0;
  int     writes_done = 0;

  radix_to_ascii_converter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_symbol      (out_symbol),
    .out_last_symbol (out_last_symbol),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] eff_base();
    if (base_reg < 2) return 64'd2;
    if (base_reg > 16) return 64'd16;
    return 64'(base_reg);
  endfunction

  // Queue the symbols of v, most significant digit first.
  function automatic void spell_value(logic [63:0] v);
    logic [63:0]  base;
    logic [3:0]   digits[$];
    logic [127:0] alphabet;
    base = eff_base();
    alphabet = {glyphs_high, glyphs_low};
    do begin
      digits.push_front(4'(v % base));
      v = v / base;
    end while (v != 0);
    foreach (digits[k])
      pending_symbols.push_back(glyph_t'{alphabet[digits[k]*8 +: 8], k == digits.size() - 1});
  endfunction

  function automatic int text_len(logic [511:0] t);
    for (int k = 63; k >= 0; k--)
      if (t[k*8 +: 8] != 8'h00) return k + 1;
    return 0;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    logic [63:0] p;
    v = {$urandom, $urandom};
    p = 64'd1;
    case ($urandom_range(0, 9))
      0: v = ($urandom_range(0, 1) != 0) ? 64'd0 : ALL_ONES;
      1: begin
        // powers of the radix and one below them
        repeat ($urandom_range(1, 63)) p = p * eff_base();
        v = p - 64'($urandom_range(0, 1));
      end
      2, 3, 4, 5: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic issue(input logic [63:0] v, input logic [511:0] text);
    int gap;
    int n;
    gap = steady ? 0 : idle_gap();
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      start <= 1'b0;
      in_value <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    n = text_len(text);
    if (n == 0) begin
      spell_value(v);
    end else begin
      for (int k = n - 1; k >= 0; k--)
        pending_symbols.push_back(glyph_t'{text[k*8 +: 8], k == 0});
    end
    values_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RADIX:        base_reg = data[RADIX_W-1:0];
      CFG_SYMBOLS_LOW:  glyphs_low = data;
      CFG_SYMBOLS_HIGH: glyphs_high = data;
      default: ;
    endcase
    writes_done++;
  endtask

  // Drop start and wait until every queued symbol has come out.
  task automatic settle();
    start <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      symbols_seen++;
      if (pending_symbols.size() == 0) begin
        $error("out_symbol 0x%02h arrived with no symbol expected", out_symbol);
        fail_count++;
      end else begin
        want = pending_symbols.pop_front();
        if (out_symbol !== want.symbol) begin
          $error("out_symbol mismatch: expected 0x%02h, got 0x%02h", want.symbol, out_symbol);
          fail_count++;
        end
        if (out_last_symbol !== want.last) begin
          $error("out_last_symbol mismatch: expected %0b, got %0b", want.last,
                 out_last_symbol);
          fail_count++;
        end
      end
    end
  end

  initial begin
    plan = '{
      '{ROW_CONVERT, CFG_RADIX,        64'd0,                 "0"},
      '{ROW_CONVERT, CFG_RADIX,        64'd9,                 "9"},
      '{ROW_CONVERT, CFG_RADIX,        64'd10,                "10"},
      '{ROW_CONVERT, CFG_RADIX,        ALL_ONES,              "18446744073709551615"},
      '{ROW_WRITE,   CFG_RADIX,        64'd16,                '0},
      // digits above 9 map to zero bytes in the reset alphabet
      '{ROW_CONVERT, CFG_RADIX,        64'hAF,                '0},
      '{ROW_WRITE,   CFG_SYMBOLS_HIGH, HEX_SYMBOLS_HIGH,      '0},
      '{ROW_CONVERT, CFG_RADIX,        ALL_ONES,              "FFFFFFFFFFFFFFFF"},
      '{ROW_CONVERT, CFG_RADIX,        64'h0123456789ABCDEF,  "123456789ABCDEF"},
      '{ROW_WRITE,   CFG_RADIX,        64'd31,                '0},
      '{ROW_CONVERT, CFG_RADIX,        64'd255,               "FF"},
      '{ROW_WRITE,   CFG_RADIX,        64'd17,                '0},
      '{ROW_CONVERT, CFG_RADIX,        64'd16,                "10"},
      '{ROW_WRITE,   CFG_RADIX,        64'd0,                 '0},
      '{ROW_CONVERT, CFG_RADIX,        64'd5,                 "101"},
      '{ROW_CONVERT, CFG_RADIX,        ALL_ONES,              '0},
      '{ROW_CONVERT, CFG_RADIX,        64'h8000000000000000,  '0},
      '{ROW_WRITE,   CFG_RADIX,        64'd1,                 '0},
      '{ROW_CONVERT, CFG_RADIX,        64'd1,                 "1"},
      '{ROW_CONVERT, CFG_RADIX,        64'd0,                 "0"},
      // only the low five bits reach the radix
      '{ROW_WRITE,   CFG_RADIX,        64'hFFFFFFFFFFFFFFE3,  '0},
      '{ROW_WRITE,   CFG_SPARE,        ALL_ONES,              '0},
      '{ROW_CONVERT, CFG_RADIX,        64'd8,                 "22"},
      '{ROW_CONVERT, CFG_RADIX,        ALL_ONES,              '0},
      '{ROW_WRITE,   CFG_SYMBOLS_LOW,  64'd0,                 '0},
      '{ROW_WRITE,   CFG_SYMBOLS_HIGH, ALL_ONES,              '0},
      '{ROW_WRITE,   CFG_RADIX,        64'd16,                '0},
      '{ROW_CONVERT, CFG_RADIX,        64'hF0F00F0F,          '0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        issue(plan[i].data, plan[i].text);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: write_reg(CFG_RADIX, 64'd2);
        1: write_reg(CFG_RADIX, 64'd16);
        2: write_reg(CFG_RADIX, 64'd31);
        3: write_reg(CFG_RADIX, 64'd0);
        default: write_reg(CFG_RADIX, {$urandom, $urandom});
      endcase
      case ($urandom_range(0, 2))
        0: begin
          write_reg(CFG_SYMBOLS_LOW, RESET_SYMBOLS_LOW);
          write_reg(CFG_SYMBOLS_HIGH, HEX_SYMBOLS_HIGH);
        end
        1: begin
          write_reg(CFG_SYMBOLS_LOW, RESET_SYMBOLS_LOW);
          write_reg(CFG_SYMBOLS_HIGH, RESET_SYMBOLS_HIGH);
        end
        default: begin
          write_reg(CFG_SYMBOLS_LOW, {$urandom, $urandom});
          write_reg(CFG_SYMBOLS_HIGH, {$urandom, $urandom});
        end
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, {$urandom, $urandom});
      // every third phase sends back to back
      steady = (ph % 3 == 2);
      repeat (52) issue(pick_value(), '0);
    end

    settle();
    repeat (40) @(posedge clk);
    $display("Converted %0d values into %0d symbols across %0d register writes.",
             values_sent, symbols_seen, writes_done);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d symbols still expected.", pending_symbols.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
